// ===== hw/rtl/mmb_pkg.sv =====
// ----------------------------------------------------------------------------
// mmb_pkg
// shared types, constants and address decode for the memory map bus
// ----------------------------------------------------------------------------
package mmb_pkg;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned CYC_W   = 7;
  localparam int unsigned IO_AW   = 7;

  localparam logic [7:0]  BYTE_FF     = 8'hFF;
  localparam logic [15:0] DMA_ADDR    = 16'hFF46;
  localparam logic [15:0] ATTR_BASE   = 16'hFE00;
  localparam logic [15:0] ECHO_OFFSET = 16'h2000;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // what an address lands on
  typedef enum logic [1:0] {
    KIND_MEM  = 2'd0,
    KIND_IO   = 2'd1,
    KIND_IE   = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] phys;
  } decode_t;

  // classified item passed from front to back
  typedef struct packed {
    cmd_t        cmd;
    decode_t     dec;
    logic [7:0]  data;
    logic        cpu;
    logic [6:0]  cycles;
    logic        in_high;
    logic        in_vram;
    logic        in_oam;
    logic        vram_open;
    logic        oam_open;
    logic        dma_wr;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CP_CHK,
    ST_CP_WR
  } state_t;

  function automatic decode_t decode(input logic [15:0] a);
    decode_t d;
    d.phys = a;
    d.kind = KIND_MEM;
    if (a <= 16'h7FFF) begin
      d.kind = KIND_MEM;
    end else if (a <= 16'h9FFF) begin
      d.kind = KIND_MEM;
    end else if (a <= 16'hBFFF) begin
      d.kind = KIND_NONE;
    end else if (a <= 16'hDFFF) begin
      d.kind = KIND_MEM;
    end else if (a <= 16'hFDFF) begin
      d.kind = KIND_MEM;
      d.phys = a - ECHO_OFFSET;
    end else if (a <= 16'hFE9F) begin
      d.kind = KIND_MEM;
    end else if (a <= 16'hFEFF) begin
      d.kind = KIND_NONE;
    end else if (a == 16'hFF00) begin
      d.kind = KIND_NONE;
    end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
      d.kind = KIND_NONE;
    end else if (a <= 16'hFF7F) begin
      d.kind = KIND_IO;
    end else if (a <= 16'hFFFE) begin
      d.kind = KIND_MEM;
    end else begin
      d.kind = KIND_IE;
    end
    return d;
  endfunction

  // post-boot value of an i/o register
  function automatic logic [7:0] io_reset_value(input logic [6:0] i);
    logic [7:0] v;
    case (i)
      7'h40:   v = 8'h91;
      7'h47:   v = 8'hFC;
      7'h48:   v = 8'hFF;
      7'h49:   v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/mmb_front.sv =====
// ----------------------------------------------------------------------------
// mmb_front
// accepts bus transactions, decodes them and queues them for the back end
// ----------------------------------------------------------------------------
module mmb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,
  input  logic [39:0]          in_tdata,
  output logic                 q_valid,
  output mmb_pkg::item_t       q_item,
  input  logic                 q_pop
);

  mmb_pkg::item_t    mem_r [2];
  logic              wp_r, wp_nxt;
  logic              rp_r, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  mmb_pkg::item_t    cls;
  logic [15:0]       a;
  logic              push;

  assign a = in_tdata[15:0];

  always_comb begin
    cls.cmd       = mmb_pkg::cmd_t'(in_tuser);
    cls.dec       = mmb_pkg::decode(a);
    cls.data      = in_tdata[23:16];
    cls.cpu       = in_tdata[24];
    cls.cycles    = in_tdata[31:25];
    cls.vram_open = in_tdata[32];
    cls.oam_open  = in_tdata[33];
    cls.in_high   = (a >= 16'hFF80) && (a <= 16'hFFFE);
    cls.in_vram   = (a >= 16'h8000) && (a <= 16'h9FFF);
    cls.in_oam    = (a >= 16'hFE00) && (a <= 16'hFE9F);
    cls.dma_wr    = in_tdata[24] && (in_tuser == mmb_pkg::CMD_WRITE) &&
                    (a == mmb_pkg::DMA_ADDR);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push  ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

endmodule

// ===== hw/rtl/mmb_back.sv =====
// ----------------------------------------------------------------------------
// mmb_back
// executes queued transactions against the memory and runs the oam copy
// ----------------------------------------------------------------------------
module mmb_back #(
  parameter int COPY_LENGTH     = 160,
  parameter int CYCLES_PER_BYTE = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 q_valid,
  input  mmb_pkg::item_t       q_item,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata
);

  localparam logic [7:0] LEN = 8'(COPY_LENGTH);
  localparam logic [7:0] CPB = 8'(CYCLES_PER_BYTE);

  logic [7:0]           mem [65536];
  logic [7:0]           mem_q_r;
  logic                 rd_en;
  logic [15:0]          rd_addr;
  logic                 wr_en;
  logic [15:0]          wr_addr;
  logic [7:0]           wr_data;

  mmb_pkg::state_t      state_r, state_nxt;
  logic                 gate_r;
  logic [127:0]         io_vld_r, io_vld_nxt;
  logic [7:0]           ie_r, ie_nxt;
  logic                 run_r, run_nxt;
  logic [7:0]           base_r, base_nxt;
  logic [7:0]           idx_r, idx_nxt;
  logic [7:0]           acc_r, acc_nxt;
  mmb_pkg::kind_t       pk_r, pk_nxt;
  logic [6:0]           pio_r, pio_nxt;
  logic                 ov_r, ov_nxt;
  logic [7:0]           ord_r, ord_nxt;
  logic                 oblk_r, oblk_nxt;
  logic                 orun_r, orun_nxt;
  logic [7:0]           oidx_r, oidx_nxt;

  mmb_pkg::item_t       it;
  logic                 blocked;
  logic                 out_free;
  logic                 res_ld;
  logic [7:0]           res_rd;
  logic                 res_blk;
  logic [7:0]           fetched;
  logic [15:0]          src;
  mmb_pkg::decode_t     sdec;

  assign it       = q_item;
  assign out_free = !ov_r || out_tready;
  assign blocked  = it.cpu && ((run_r && !it.in_high) ||
                    (gate_r && ((it.in_vram && !it.vram_open) ||
                                (it.in_oam && !it.oam_open))));
  assign src      = {base_r, 8'h00} + 16'(idx_r);
  assign sdec     = mmb_pkg::decode(src);

  always_comb begin
    case (pk_r)
      mmb_pkg::KIND_NONE: fetched = mmb_pkg::BYTE_FF;
      mmb_pkg::KIND_IE:   fetched = ie_r;
      mmb_pkg::KIND_IO:   fetched = io_vld_r[pio_r] ? mem_q_r :
                                    mmb_pkg::io_reset_value(pio_r);
      default:            fetched = mem_q_r;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    io_vld_nxt = io_vld_r;
    ie_nxt     = ie_r;
    run_nxt    = run_r;
    base_nxt   = base_r;
    idx_nxt    = idx_r;
    acc_nxt    = acc_r;
    pk_nxt     = pk_r;
    pio_nxt    = pio_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = it.dec.phys;
    wr_en      = 1'b0;
    wr_addr    = it.dec.phys;
    wr_data    = it.data;
    res_ld     = 1'b0;
    res_rd     = 8'h00;
    res_blk    = 1'b0;

    case (state_r)
      mmb_pkg::ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (it.cmd)
            mmb_pkg::CMD_READ: begin
              if (blocked) begin
                res_ld  = 1'b1;
                res_rd  = mmb_pkg::BYTE_FF;
                res_blk = 1'b1;
              end else if (it.dec.kind == mmb_pkg::KIND_MEM ||
                           it.dec.kind == mmb_pkg::KIND_IO) begin
                rd_en     = 1'b1;
                pk_nxt    = it.dec.kind;
                pio_nxt   = it.dec.phys[6:0];
                state_nxt = mmb_pkg::ST_RD;
              end else begin
                res_ld = 1'b1;
                res_rd = (it.dec.kind == mmb_pkg::KIND_IE) ? ie_r : mmb_pkg::BYTE_FF;
              end
            end
            mmb_pkg::CMD_WRITE: begin
              res_ld = 1'b1;
              if (it.dma_wr) begin
                wr_en                        = 1'b1;
                io_vld_nxt[it.dec.phys[6:0]] = 1'b1;
                run_nxt                      = 1'b1;
                base_nxt                     = it.data;
                idx_nxt                      = 8'd0;
                acc_nxt                      = 8'd0;
              end else if (blocked) begin
                res_blk = 1'b1;
              end else begin
                case (it.dec.kind)
                  mmb_pkg::KIND_MEM: wr_en = 1'b1;
                  mmb_pkg::KIND_IO: begin
                    wr_en                        = 1'b1;
                    io_vld_nxt[it.dec.phys[6:0]] = 1'b1;
                  end
                  mmb_pkg::KIND_IE: ie_nxt = it.data;
                  default: ;
                endcase
              end
            end
            mmb_pkg::CMD_TICK: begin
              if (run_r) begin
                acc_nxt   = acc_r + 8'(it.cycles);
                state_nxt = mmb_pkg::ST_CP_CHK;
              end else begin
                res_ld = 1'b1;
              end
            end
            default: res_ld = 1'b1;
          endcase
        end
      end
      mmb_pkg::ST_RD: begin
        res_ld    = 1'b1;
        res_rd    = fetched;
        state_nxt = mmb_pkg::ST_IDLE;
      end
      mmb_pkg::ST_CP_CHK: begin
        if (run_r && acc_r >= CPB) begin
          acc_nxt   = acc_r - CPB;
          rd_en     = (sdec.kind == mmb_pkg::KIND_MEM) || (sdec.kind == mmb_pkg::KIND_IO);
          rd_addr   = sdec.phys;
          pk_nxt    = sdec.kind;
          pio_nxt   = sdec.phys[6:0];
          state_nxt = mmb_pkg::ST_CP_WR;
        end else begin
          res_ld    = 1'b1;
          state_nxt = mmb_pkg::ST_IDLE;
        end
      end
      mmb_pkg::ST_CP_WR: begin
        wr_en     = 1'b1;
        wr_addr   = mmb_pkg::ATTR_BASE + 16'(idx_r);
        wr_data   = fetched;
        idx_nxt   = idx_r + 8'd1;
        if (idx_nxt >= LEN) begin
          run_nxt = 1'b0;
          acc_nxt = 8'd0;
        end
        state_nxt = mmb_pkg::ST_CP_CHK;
      end
      default: state_nxt = mmb_pkg::ST_IDLE;
    endcase

    ov_nxt   = ov_r && !out_tready;
    ord_nxt  = ord_r;
    oblk_nxt = oblk_r;
    orun_nxt = orun_r;
    oidx_nxt = oidx_r;
    if (res_ld) begin
      ov_nxt   = 1'b1;
      ord_nxt  = res_rd;
      oblk_nxt = res_blk;
      orun_nxt = run_nxt;
      oidx_nxt = idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mmb_pkg::ST_IDLE;
      gate_r   <= 1'b0;
      io_vld_r <= '0;
      ie_r     <= 8'h00;
      run_r    <= 1'b0;
      base_r   <= 8'h00;
      idx_r    <= 8'h00;
      acc_r    <= 8'h00;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_wr_en) begin
        gate_r <= cfg_wr_data;
      end
      io_vld_r <= io_vld_nxt;
      ie_r     <= ie_nxt;
      run_r    <= run_nxt;
      base_r   <= base_nxt;
      idx_r    <= idx_nxt;
      acc_r    <= acc_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pk_r   <= pk_nxt;
    pio_r  <= pio_nxt;
    ord_r  <= ord_nxt;
    oblk_r <= oblk_nxt;
    orun_r <= orun_nxt;
    oidx_r <= oidx_nxt;
  end

  // single port memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, oidx_r, orun_r, oblk_r, ord_r};

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LEN) else $error("copy index past copy length");
  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> acc_r == 8'd0) else $error("cycle credit left with no copy");
  a_cp_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mmb_pkg::ST_CP_WR |=> state_r == mmb_pkg::ST_CP_CHK)
    else $error("copy write not followed by check");
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!ov_r || out_tready)) else $error("item taken with result slot busy");

endmodule

// ===== hw/rtl/memory_map_bus_with_oam_dma.sv =====
// ----------------------------------------------------------------------------
// memory_map_bus_with_oam_dma
// 16-bit address map for byte reads and writes with an attribute memory copy
// ----------------------------------------------------------------------------
//  channel | direction | fields (lsb first)
//  in_     | slave     | tuser: command; tdata: address, write_data,
//          |           |   from_processor, tick_cycles, video_ram_open,
//          |           |   attribute_ram_open
//  out_    | master    | tdata: read_data, access_blocked, copy_active,
//          |           |   copy_bytes_done
//  cfg_    | write     | wr_data: ppu_gating_enabled
//
// a write, a blocked or unmapped read, an unused command and a tick with no copy
// running are answered from idle, a memory or i/o read goes through a read state
// (registered read port); a tick with a copy running alternates check and write
// states: each byte is one read and one write on the single memory port
// reset (rst_n low, synchronous) restores post-boot i/o values, no clearing pass
// a two-entry queue between front and back absorbs input while the back works;
// a full result register stalls the back only
// ----------------------------------------------------------------------------
module memory_map_bus_with_oam_dma #(
  parameter int COPY_LENGTH     = 160,
  parameter int CYCLES_PER_BYTE = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,  // ppu_gating_enabled
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,     // command
  input  logic [39:0] in_tdata,     // address, write_data, from_processor,
                                    // tick_cycles, video_ram_open, attribute_ram_open
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata     // read_data, access_blocked, copy_active,
                                    // copy_bytes_done
);

  logic              q_valid;
  logic              q_pop;
  mmb_pkg::item_t    q_item;

  // front: accept and decode
  mmb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // back: memory, copy engine and result register
  mmb_back #(
    .COPY_LENGTH     (COPY_LENGTH),
    .CYCLES_PER_BYTE (CYCLES_PER_BYTE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
